[hw/rtl/brpl_pkg.sv]
// shared types and constants for the buffer row provenance ledger
// no dependencies; imported by every module of the block
package brpl_pkg;

   // defaults for the top-level parameters
   localparam int DEF_NUM_SLOTS = 4;
   localparam int DEF_MAX_ROWS  = 64;

   // fixed field widths
   localparam int ID_W       = 16;
   localparam int ROWS_W     = 7;
   localparam int ROW_W      = 6;
   localparam int SLOT_W     = 2;
   localparam int TYPE_W     = 3;
   localparam int STAT_W     = 4;
   localparam int CNT_W      = 32;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 16;
   localparam int NUM_CFG_ROWS = 4;

   // configuration register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_ROWS_SLOT0  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_ROWS_SLOT1  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_ROWS_SLOT2  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_ROWS_SLOT3  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_ANY_WRITER  = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_NO_TAG      = 3'd5;

   // reset value of the writer and tag wildcard codes
   localparam logic [ID_W-1:0] WILDCARD_RESET = 16'hFFFF;

   typedef enum logic [TYPE_W-1:0] {
      REQ_WRITE,
      REQ_EXPECT,
      REQ_VERIFY,
      REQ_CANARY,
      REQ_RELEASE
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      STS_OK,
      STS_PARAM,
      STS_NOSLOT,
      STS_RANGE,
      STS_NEVER,
      STS_CANARY,
      STS_RELEASED,
      STS_WRITER,
      STS_TAG
   } status_type;

   typedef enum logic [2:0] {
      ROW_UNWRITTEN,
      ROW_WRITTEN,
      ROW_READ,
      ROW_CANARY,
      ROW_RELEASED
   } row_state_type;

   // one ledger entry as held in the row memory
   typedef struct packed {
      row_state_type   st;
      logic [ID_W-1:0] writer;
      logic [ID_W-1:0] tag;
      logic            has_exp;
      logic [ID_W-1:0] want_writer;
      logic [ID_W-1:0] want_tag;
   } row_rec_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_CHECK,
      FSM_READ,
      FSM_MODIFY,
      FSM_FINISH
   } fsm_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic check;
      logic rd_en;
      logic mod_en;
      logic step;
      logic load_rsp;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic pre_err;
      logic last_row;
   } dp_status_type;

endpackage

[hw/rtl/buffer_row_provenance_ledger.sv]
// top level of the buffer row provenance ledger
// depends on brpl_pkg, brpl_ctrl and brpl_dpath
//
// Usage:
//   Requests arrive on req_valid/req_stall with their fields on req_* ports;
//   a transfer happens when req_valid is high and req_stall low. Each request
//   yields exactly one response on rsp_valid/rsp_stall carrying a status and
//   the counter snapshot.
//   Registers are written through csr_wr_en/csr_index/csr_data while idle.
//   Sequence: a rejected request (bad type or wildcard writer, no slot, bad
//   range) goes from the check state straight to the finish state. A request
//   that touches rows passes, per row, a memory read state and then an update
//   and write back state, as the single-port row memory read-modify-write
//   needs; an expect or verify visits one row, a range write its N rows and
//   a canary/release mark every row of the slot. One request is in flight at
//   a time; req_stall is high from transfer until the response is loaded.
//   The response sits in an output register, so the next request is taken
//   while the receiver stalls; a finished result waits only if the register
//   is still full. Reset clears the ledger, counters and config registers at once.
module buffer_row_provenance_ledger
   import brpl_pkg::*;
#(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS,
   parameter int MAX_ROWS  = DEF_MAX_ROWS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TYPE_W-1:0]     req_req_type,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [ROW_W-1:0]      req_row_index,
   input  logic [ROWS_W-1:0]     req_row_count,
   input  logic [ID_W-1:0]       req_writer_id,
   input  logic [ID_W-1:0]       req_queue_tag,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [CNT_W-1:0]      rsp_sequence_res,
   output logic [CNT_W-1:0]      rsp_double_writes,
   output logic [CNT_W-1:0]      rsp_slot_writes,
   output logic [CNT_W-1:0]      rsp_slot_reads,
   output logic [CNT_W-1:0]      rsp_slot_breaks
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_sts;

   // controller
   brpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_sts    (dp_sts),
      .cmd       (cmd)
   );

   // datapath
   brpl_dpath #(
      .NUM_SLOTS (NUM_SLOTS),
      .MAX_ROWS  (MAX_ROWS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_sts            (dp_sts),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_req_type      (req_req_type),
      .req_slot          (req_slot),
      .req_row_index     (req_row_index),
      .req_row_count     (req_row_count),
      .req_writer_id     (req_writer_id),
      .req_queue_tag     (req_queue_tag),
      .rsp_status        (rsp_status),
      .rsp_sequence_res  (rsp_sequence_res),
      .rsp_double_writes (rsp_double_writes),
      .rsp_slot_writes   (rsp_slot_writes),
      .rsp_slot_reads    (rsp_slot_reads),
      .rsp_slot_breaks   (rsp_slot_breaks)
   );

endmodule

[hw/rtl/brpl_ctrl.sv]
// controller state machine for the ledger: sequences check, row walk and response
// depends on brpl_pkg
module brpl_ctrl
   import brpl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type dp_sts,
   output ctrl_cmd_type  cmd
);

   fsm_type state_ff, state_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // state and response valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = FSM_CHECK;
            end
         end
         FSM_CHECK: begin
            cmd.check = 1'b1;
            state_in  = dp_sts.pre_err ? FSM_FINISH : FSM_READ;
         end
         FSM_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = FSM_MODIFY;
         end
         FSM_MODIFY: begin
            cmd.mod_en = 1'b1;
            if (dp_sts.last_row) begin
               state_in = FSM_FINISH;
            end else begin
               cmd.step = 1'b1;
               state_in = FSM_READ;
            end
         end
         FSM_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // response valid: set on load, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_stall = (state_ff != FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/brpl_dpath.sv]
// datapath for the ledger: request and config registers, row memory, counters
// depends on brpl_pkg; driven by brpl_ctrl commands
module brpl_dpath
   import brpl_pkg::*;
#(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS,
   parameter int MAX_ROWS  = DEF_MAX_ROWS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         dp_sts,
   input  logic                  csr_wr_en,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_data,
   input  logic [TYPE_W-1:0]     req_req_type,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [ROW_W-1:0]      req_row_index,
   input  logic [ROWS_W-1:0]     req_row_count,
   input  logic [ID_W-1:0]       req_writer_id,
   input  logic [ID_W-1:0]       req_queue_tag,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [CNT_W-1:0]      rsp_sequence_res,
   output logic [CNT_W-1:0]      rsp_double_writes,
   output logic [CNT_W-1:0]      rsp_slot_writes,
   output logic [CNT_W-1:0]      rsp_slot_reads,
   output logic [CNT_W-1:0]      rsp_slot_breaks
);

   localparam int DEPTH  = NUM_SLOTS * MAX_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SIDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // request registers
   logic [TYPE_W-1:0] type_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [ROWS_W-1:0] cnt_ff;
   logic [ID_W-1:0]   wr_ff;
   logic [ID_W-1:0]   tag_ff;

   // configuration registers
   logic [ROWS_W-1:0] rows_ff [NUM_CFG_ROWS];
   logic [ID_W-1:0]   any_ff;
   logic [ID_W-1:0]   notag_ff;

   // walk registers
   logic [ROWS_W-1:0] ptr_ff;
   logic [ROWS_W-1:0] last_ff;
   status_type        status_ff;

   // counters
   logic [CNT_W-1:0] seq_ff;
   logic [CNT_W-1:0] dbl_ff;
   logic [CNT_W-1:0] wcnt_ff [NUM_SLOTS];
   logic [CNT_W-1:0] rcnt_ff [NUM_SLOTS];
   logic [CNT_W-1:0] bcnt_ff [NUM_SLOTS];

   // row memory with per-entry valid bits
   row_rec_type     mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   row_rec_type     rd_ff;
   logic            rd_vld_ff;

   // response registers
   logic [STAT_W-1:0] rsp_status_ff;
   logic [CNT_W-1:0]  rsp_seq_ff;
   logic [CNT_W-1:0]  rsp_dbl_ff;
   logic [CNT_W-1:0]  rsp_wr_ff;
   logic [CNT_W-1:0]  rsp_rd_ff;
   logic [CNT_W-1:0]  rsp_brk_ff;

   logic              slot_ok;
   logic [SIDX_W-1:0] sidx;
   logic [ROWS_W-1:0] cfg_n;
   logic [ROWS_W-1:0] n_rows;
   status_type        pre_status;
   logic [ADDR_W-1:0] addr;
   row_rec_type       old_rec;
   row_rec_type       new_rec;
   status_type        ver_status;
   logic              dbl_hit;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         type_ff <= req_req_type;
         slot_ff <= req_slot;
         row_ff  <= req_row_index;
         cnt_ff  <= req_row_count;
         wr_ff   <= req_writer_id;
         tag_ff  <= req_queue_tag;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG_ROWS; i++) begin
            rows_ff[i] <= '0;
         end
         any_ff   <= WILDCARD_RESET;
         notag_ff <= WILDCARD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CFG_ROWS_SLOT0: rows_ff[0] <= csr_data[ROWS_W-1:0];
            CFG_ROWS_SLOT1: rows_ff[1] <= csr_data[ROWS_W-1:0];
            CFG_ROWS_SLOT2: rows_ff[2] <= csr_data[ROWS_W-1:0];
            CFG_ROWS_SLOT3: rows_ff[3] <= csr_data[ROWS_W-1:0];
            CFG_ANY_WRITER: any_ff     <= csr_data[ID_W-1:0];
            CFG_NO_TAG:     notag_ff   <= csr_data[ID_W-1:0];
            default: ;
         endcase
      end
   end

   // rows in the addressed slot, clamped to the slot size
   assign slot_ok = (32'(slot_ff) < NUM_SLOTS);
   assign sidx    = SIDX_W'(slot_ff);
   assign cfg_n   = rows_ff[slot_ff];
   assign n_rows  = !slot_ok ? '0 :
                    (32'(cfg_n) > MAX_ROWS) ? ROWS_W'(MAX_ROWS) : cfg_n;

   // request checks ahead of any row access
   always_comb begin
      pre_status = STS_OK;
      if (type_ff > REQ_RELEASE) begin
         pre_status = STS_PARAM;
      end else if (type_ff == REQ_WRITE && wr_ff == any_ff) begin
         pre_status = STS_PARAM;
      end else if (n_rows == '0) begin
         pre_status = STS_NOSLOT;
      end else if (type_ff == REQ_WRITE) begin
         if (cnt_ff == '0 || ROWS_W'(row_ff) >= n_rows ||
             cnt_ff > (n_rows - ROWS_W'(row_ff))) begin
            pre_status = STS_RANGE;
         end
      end else if (type_ff == REQ_EXPECT || type_ff == REQ_VERIFY) begin
         if (ROWS_W'(row_ff) >= n_rows) begin
            pre_status = STS_RANGE;
         end
      end
   end

   assign dp_sts.pre_err  = (pre_status != STS_OK);
   assign dp_sts.last_row = (ptr_ff == last_ff);

   assign addr = ADDR_W'(32'(sidx) * MAX_ROWS) + ADDR_W'(ptr_ff);

   // row update and verify classification
   always_comb begin
      old_rec    = rd_vld_ff ? rd_ff : '0;
      new_rec    = old_rec;
      ver_status = STS_OK;
      dbl_hit    = 1'b0;
      case (type_ff)
         REQ_WRITE: begin
            dbl_hit        = (old_rec.st == ROW_WRITTEN) && (old_rec.writer != wr_ff);
            new_rec.st     = ROW_WRITTEN;
            new_rec.writer = wr_ff;
            new_rec.tag    = tag_ff;
         end
         REQ_EXPECT: begin
            new_rec.has_exp     = 1'b1;
            new_rec.want_writer = wr_ff;
            new_rec.want_tag    = tag_ff;
         end
         REQ_VERIFY: begin
            case (old_rec.st)
               ROW_UNWRITTEN: ver_status = STS_NEVER;
               ROW_CANARY:    ver_status = STS_CANARY;
               ROW_RELEASED:  ver_status = STS_RELEASED;
               default: begin
                  if (old_rec.has_exp && old_rec.want_writer != any_ff &&
                      old_rec.writer != old_rec.want_writer) begin
                     ver_status = STS_WRITER;
                  end else if (old_rec.has_exp && old_rec.want_tag != notag_ff &&
                               old_rec.tag != old_rec.want_tag) begin
                     ver_status = STS_TAG;
                  end
               end
            endcase
            if (ver_status == STS_OK) begin
               new_rec.st = ROW_READ;
            end
         end
         REQ_CANARY:  new_rec.st = ROW_CANARY;
         REQ_RELEASE: new_rec.st = ROW_RELEASED;
         default: ;
      endcase
   end

   // row memory read and write
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff <= mem[addr];
      end
      if (cmd.mod_en) begin
         mem[addr] <= new_rec;
      end
   end

   // valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.rd_en) begin
            rd_vld_ff <= vld_ff[addr];
         end
         if (cmd.mod_en) begin
            vld_ff[addr] <= 1'b1;
         end
      end
   end

   // row walk bounds and result status
   always_ff @(posedge clock) begin
      if (cmd.check) begin
         status_ff <= pre_status;
         case (type_ff)
            REQ_WRITE: begin
               ptr_ff  <= ROWS_W'(row_ff);
               last_ff <= ROWS_W'(row_ff) + cnt_ff - ROWS_W'(1);
            end
            REQ_CANARY, REQ_RELEASE: begin
               ptr_ff  <= '0;
               last_ff <= n_rows - ROWS_W'(1);
            end
            default: begin
               ptr_ff  <= ROWS_W'(row_ff);
               last_ff <= ROWS_W'(row_ff);
            end
         endcase
      end else begin
         if (cmd.step) begin
            ptr_ff <= ptr_ff + ROWS_W'(1);
         end
         if (cmd.mod_en && type_ff == REQ_VERIFY) begin
            status_ff <= ver_status;
         end
      end
   end

   // global and per-slot counters
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
         dbl_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            wcnt_ff[i] <= '0;
            rcnt_ff[i] <= '0;
            bcnt_ff[i] <= '0;
         end
      end else begin
         if (cmd.check && pre_status == STS_OK && type_ff == REQ_WRITE) begin
            seq_ff        <= seq_ff + CNT_W'(1);
            wcnt_ff[sidx] <= wcnt_ff[sidx] + CNT_W'(1);
         end
         if (cmd.mod_en && dbl_hit) begin
            dbl_ff <= dbl_ff + CNT_W'(1);
         end
         if (cmd.mod_en && type_ff == REQ_VERIFY) begin
            if (ver_status == STS_OK) begin
               rcnt_ff[sidx] <= rcnt_ff[sidx] + CNT_W'(1);
            end else begin
               bcnt_ff[sidx] <= bcnt_ff[sidx] + CNT_W'(1);
            end
         end
      end
   end

   // response registers
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_seq_ff    <= seq_ff;
         rsp_dbl_ff    <= dbl_ff;
         rsp_wr_ff     <= slot_ok ? wcnt_ff[sidx] : '0;
         rsp_rd_ff     <= slot_ok ? rcnt_ff[sidx] : '0;
         rsp_brk_ff    <= slot_ok ? bcnt_ff[sidx] : '0;
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_sequence_res  = rsp_seq_ff;
   assign rsp_double_writes = rsp_dbl_ff;
   assign rsp_slot_writes   = rsp_wr_ff;
   assign rsp_slot_reads    = rsp_rd_ff;
   assign rsp_slot_breaks   = rsp_brk_ff;

endmodule

[hw/rtl/brpl_checker.sv]
// port-level checks for the ledger, bound to the top level
// depends on brpl_pkg
module brpl_checker
   import brpl_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [CNT_W-1:0] rsp_sequence_res
);

   // a stalled response stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its sequence number
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_sequence_res))
      else $error("response payload changed while stalled");

   // reset leaves no response pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request at a time: busy right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

endmodule

bind buffer_row_provenance_ledger brpl_checker u_brpl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sequence_res (rsp_sequence_res)
);
